FILE: hdl/hbls_pkg.sv
package hbls_pkg;

  // Capacity of the sorted hit store.
  localparam int unsigned MaxHits = 32;
  // Fill count holds 0 to MaxHits inclusive.
  localparam int unsigned CountW  = $clog2(MaxHits + 1);
  localparam int unsigned EntryW  = 64;

  localparam logic [31:0] SignFlip = 32'h8000_0000;

  typedef logic [EntryW-1:0] entry_t;
  typedef logic [CountW-1:0] count_t;

  typedef enum logic {
    StCollect,
    StEmit
  } state_e;

  // Controller to datapath.
  typedef struct packed {
    logic ins;  // insert the hit on the input channel
    logic pop;  // drop the head entry, advance the rest
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic last;  // exactly one entry left in the store
  } status_t;

  // Pack so that one unsigned compare gives x, then y, then signed cluster order.
  function automatic entry_t pack_hit(logic [15:0] x, logic [15:0] y, logic [31:0] cid);
    return {x, y, cid ^ SignFlip};
  endfunction

  function automatic logic [31:0] unpack_cluster(entry_t e);
    return e[31:0] ^ SignFlip;
  endfunction

endpackage

FILE: hdl/hbls_hit_if.sv
interface hbls_hit_if;
  logic               valid;
  logic               ready;
  logic        [15:0] hit_x;
  logic        [15:0] hit_y;
  logic signed [31:0] cluster_id;
  logic               bin_end;

  modport source (output valid, output hit_x, output hit_y, output cluster_id,
                  output bin_end, input ready);
  modport sink   (input valid, input hit_x, input hit_y, input cluster_id,
                  input bin_end, output ready);
endinterface

FILE: hdl/hbls_res_if.sv
interface hbls_res_if;
  logic               valid;
  logic               ready;
  logic        [15:0] out_x;
  logic        [15:0] out_y;
  logic signed [31:0] out_cluster;
  logic               run_last;
  logic               overflowed;

  modport source (output valid, output out_x, output out_y, output out_cluster,
                  output run_last, output overflowed, input ready);
  modport sink   (input valid, input out_x, input out_y, input out_cluster,
                  input run_last, input overflowed, output ready);
endinterface

FILE: hdl/hbls_dp.sv
module hbls_dp (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  hbls_pkg::cmd_t          cmd_i,
  input  logic [15:0]             hit_x_i,
  input  logic [15:0]             hit_y_i,
  input  logic [31:0]             cluster_id_i,
  output hbls_pkg::status_t       status_o,
  output hbls_pkg::entry_t        head_o,
  output logic                    ovf_o
);

  hbls_pkg::entry_t cell_q [hbls_pkg::MaxHits];
  hbls_pkg::entry_t cell_d [hbls_pkg::MaxHits];
  hbls_pkg::count_t count_q, count_d;
  logic             ovf_q, ovf_d;

  hbls_pkg::entry_t             new_e;
  logic                         full;
  logic [hbls_pkg::MaxHits-1:0] gt;

  assign new_e = hbls_pkg::pack_hit(hit_x_i, hit_y_i, cluster_id_i);
  assign full  = (count_q == hbls_pkg::CountW'(hbls_pkg::MaxHits));

  // Empty cells count as larger than any hit, so gt is zeros then ones.
  for (genvar g = 0; g < hbls_pkg::MaxHits; g++) begin : g_cmp
    assign gt[g] = (hbls_pkg::CountW'(g) >= count_q) || (cell_q[g] > new_e);
  end

  always_comb begin
    cell_d  = cell_q;
    count_d = count_q;
    ovf_d   = ovf_q;
    if (cmd_i.ins) begin
      if (full) begin
        ovf_d = 1'b1;
      end else begin
        count_d = count_q + hbls_pkg::CountW'(1);
        if (gt[0]) begin
          cell_d[0] = new_e;
        end
        for (int i = 1; i < hbls_pkg::MaxHits; i++) begin
          if (gt[i]) begin
            cell_d[i] = gt[i-1] ? cell_q[i-1] : new_e;
          end
        end
      end
    end else if (cmd_i.pop) begin
      count_d = count_q - hbls_pkg::CountW'(1);
      if (status_o.last) begin
        ovf_d = 1'b0;
      end
      for (int i = 0; i < hbls_pkg::MaxHits - 1; i++) begin
        cell_d[i] = cell_q[i+1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cell_q <= cell_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      ovf_q   <= 1'b0;
    end else begin
      count_q <= count_d;
      ovf_q   <= ovf_d;
    end
  end

  assign status_o.last = (count_q == hbls_pkg::CountW'(1));
  assign head_o        = cell_q[0];
  assign ovf_o         = ovf_q;

endmodule

FILE: hdl/hbls_ctrl.sv
module hbls_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              hit_valid_i,
  input  logic              hit_bin_end_i,
  output logic              hit_ready_o,
  output logic              res_valid_o,
  input  logic              res_ready_i,
  input  hbls_pkg::status_t status_i,
  output hbls_pkg::cmd_t    cmd_o
);

  hbls_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= hbls_pkg::StCollect;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    hit_ready_o = 1'b0;
    res_valid_o = 1'b0;
    cmd_o       = '0;
    case (state_q)
      hbls_pkg::StCollect: begin
        hit_ready_o = 1'b1;
        if (hit_valid_i) begin
          cmd_o.ins = 1'b1;
          if (hit_bin_end_i) begin
            state_d = hbls_pkg::StEmit;
          end
        end
      end
      hbls_pkg::StEmit: begin
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          cmd_o.pop = 1'b1;
          if (status_i.last) begin
            state_d = hbls_pkg::StCollect;
          end
        end
      end
      default: begin
        state_d = hbls_pkg::StCollect;
      end
    endcase
  end

endmodule

FILE: hdl/hit_bin_lexicographic_sorter.sv
// Hit bin sorter. Hits of one grid bin arrive as words on hit_i, one per
// cycle, and are kept in a row of 32 cells that stays sorted at all times:
// each new hit is compared against every cell in parallel and slotted in,
// the larger cells moving up by one. The order is x first, then y, then the
// signed cluster id. The word flagged bin_end closes the bin; from the next
// cycle the sorted hits leave on res_o one word per cycle while res_o is
// ready, smallest first, straight from the head cell, with run_last on the
// final word. While the bin is being read out hit_i is held off (ready low).
// Hits beyond the 32nd of a bin are dropped, including a bin_end hit, and
// every word of that bin's readout then carries overflowed. The store and
// the overflow flag are empty again after run_last is taken; no clearing
// pass is needed after reset.
module hit_bin_lexicographic_sorter (
  input  logic       clk_i,
  input  logic       rst_ni,
  hbls_hit_if.sink   hit_i,
  hbls_res_if.source res_o
);

  hbls_pkg::cmd_t    cmd;
  hbls_pkg::status_t status;
  hbls_pkg::entry_t  head;
  logic              ovf;

  // Sequencer: collect until bin end, then drain.
  hbls_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .hit_valid_i   (hit_i.valid),
    .hit_bin_end_i (hit_i.bin_end),
    .hit_ready_o   (hit_i.ready),
    .res_valid_o   (res_o.valid),
    .res_ready_i   (res_o.ready),
    .status_i      (status),
    .cmd_o         (cmd)
  );

  // Sorted cell row, fill count and overflow flag.
  hbls_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .hit_x_i      (hit_i.hit_x),
    .hit_y_i      (hit_i.hit_y),
    .cluster_id_i (hit_i.cluster_id),
    .status_o     (status),
    .head_o       (head),
    .ovf_o        (ovf)
  );

  // Unpack the head cell onto the result word.
  assign res_o.out_x       = head[63:48];
  assign res_o.out_y       = head[47:32];
  assign res_o.out_cluster = hbls_pkg::unpack_cluster(head);
  assign res_o.run_last    = status.last;
  assign res_o.overflowed  = ovf;

  // Input and output never open together.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(hit_i.ready && res_o.valid))
    else $error("input accepted during readout");

  // A closing hit always starts a readout on the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (hit_i.valid && hit_i.ready && hit_i.bin_end) |=> res_o.valid)
    else $error("bin end did not start readout");

  // Taking the final word returns the block to collecting.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && res_o.ready && res_o.run_last) |=> (hit_i.ready && !res_o.overflowed))
    else $error("run did not close cleanly");

  // The overflow mark holds across one readout.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && $past(res_o.valid)) |-> $stable(res_o.overflowed))
    else $error("overflow flag changed during readout");

endmodule
